FILE: design/asc_pkg.sv
// shared types, constants and codes of the adaptive step counter
package asc_pkg;

	// sample width and derived widths of the magnitude datapath
	localparam int ACCEL_BITS = 16;
	localparam int SUM_W      = 2 * ACCEL_BITS + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int CNT_W      = $clog2(ROOT_W);

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_FILTER_GAIN   = 3'd0;
	localparam cfg_index_t REG_THR_START     = 3'd1;
	localparam cfg_index_t REG_THR_INCREMENT = 3'd2;
	localparam cfg_index_t REG_THR_DECREMENT = 3'd3;
	localparam cfg_index_t REG_THR_FLOOR     = 3'd4;
	localparam cfg_index_t REG_STEP_GAP      = 3'd5;

	// register reset values
	localparam logic [15:0] RST_FILTER_GAIN   = 16'd19661;
	localparam logic [15:0] RST_THR_START     = 16'd1408;
	localparam logic [15:0] RST_THR_INCREMENT = 16'd64;
	localparam logic [15:0] RST_THR_DECREMENT = 16'd6;
	localparam logic [15:0] RST_THR_FLOOR     = 16'd1344;
	localparam logic [15:0] RST_STEP_GAP      = 16'd300;

	// 1.5 m/s^2 in 1/128 units
	localparam logic [16:0] REARM_MARGIN = 17'd192;
	localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;

	// axis select codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [ACCEL_BITS-1:0] accel_x;
		logic signed [ACCEL_BITS-1:0] accel_y;
		logic signed [ACCEL_BITS-1:0] accel_z;
		logic [31:0]                  now_ms;
	} in_item_t;

	typedef struct packed {
		logic [15:0] smoothed_level;
		logic        step_pulse;
		logic [31:0] step_total;
		logic [15:0] current_threshold;
	} out_item_t;

	typedef struct packed {
		logic [15:0] filter_gain;
		logic [15:0] threshold_start;
		logic [15:0] threshold_increment;
		logic [15:0] threshold_decrement;
		logic [15:0] threshold_floor;
		logic [15:0] step_gap_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_FILT_A,
		ST_FILT_B,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       square;
		logic [1:0] axis;
		logic       root_step;
		logic       filt_a;
		logic       filt_b;
		logic       decide;
		logic       finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} ctrl_status_t;

endpackage

FILE: design/asc_ctrl.sv
// sequencer of the step counter: walks one item through the datapath
module asc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  asc_pkg::ctrl_status_t status,
	output asc_pkg::ctrl_cmd_t    cmd
);
	import asc_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;

	localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXIS_Z);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE: if (cnt_q == SQ_LAST) state_d = ST_ROOT;
			ST_ROOT:   if (cnt_q == ROOT_LAST) state_d = ST_FILT_A;
			ST_FILT_A: state_d = ST_FILT_B;
			ST_FILT_B: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_FINISH;
			ST_FINISH: if (!status.out_blocked) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		cmd.axis = cnt_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQUARE: cmd.square    = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_FILT_A: cmd.filt_a    = 1'b1;
			ST_FILT_B: cmd.filt_b    = 1'b1;
			ST_DECIDE: cmd.decide    = 1'b1;
			ST_FINISH: cmd.finish    = !status.out_blocked;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQUARE || state_q == ST_ROOT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/asc_datapath.sv
// magnitude, low-pass filter, threshold tracking and result register
module asc_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  asc_pkg::ctrl_cmd_t    cmd,
	output asc_pkg::ctrl_status_t status,
	input  asc_pkg::in_item_t     in_data,
	input  asc_pkg::cfg_t         cfg,
	input  logic                  thr_load,
	input  logic [15:0]           thr_load_val,
	input  logic                  out_ready,
	output logic                  out_valid,
	output asc_pkg::out_item_t    out_data
);
	import asc_pkg::*;

	// sample registers
	logic signed [ACCEL_BITS-1:0] ax_q, ay_q, az_q;
	logic [31:0]                  now_q;

	// sum of squares and root iteration
	logic [SUM_W-1:0]  sum_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [32:0]       acc_q;

	// detector state
	logic [15:0] level_q;
	logic [15:0] thr_q;
	logic        latched_q;
	logic [31:0] last_ms_q;
	logic [31:0] count_q;
	logic        pulse_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic signed [ACCEL_BITS-1:0] axis_sel;
	logic [ACCEL_BITS-1:0]        axis_abs;
	logic [2*ACCEL_BITS-1:0]      axis_sq;
	logic [REM_W-1:0]             rem_sh;
	logic [REM_W-1:0]             trial;
	logic [ROOT_W+15:0]           root_ext;
	logic [15:0]                  mag_sat;
	logic [16:0]                  gain_inv;
	logic [32:0]                  filt_sum;
	logic [31:0]                  elapsed;
	logic                         hit;
	logic [16:0]                  thr_rise;
	logic [16:0]                  thr_lim;
	logic [15:0]                  thr_up;
	logic [15:0]                  thr_dn;
	logic                         rearm;

	always_comb begin
		unique case (cmd.axis)
			AXIS_X:  axis_sel = ax_q;
			AXIS_Y:  axis_sel = ay_q;
			default: axis_sel = az_q;
		endcase
	end

	assign axis_abs = axis_sel[ACCEL_BITS-1] ? ACCEL_BITS'(-axis_sel) : axis_sel;
	assign axis_sq  = axis_abs * axis_abs;

	// one root bit per step, two radicand bits brought down
	assign rem_sh = {rem_q[REM_W-3:0], sum_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	assign root_ext = (ROOT_W + 16)'(root_q);
	assign mag_sat  = (|root_ext[ROOT_W+15:16]) ? LEVEL_MAX : root_ext[15:0];

	assign gain_inv = 17'h10000 - {1'b0, cfg.filter_gain};
	assign filt_sum = acc_q + (gain_inv * level_q) + 33'd32768;

	assign elapsed  = now_q - last_ms_q;
	assign hit      = (level_q > thr_q) && !latched_q && (elapsed > {16'd0, cfg.step_gap_ms});
	assign thr_rise = {1'b0, thr_q} + {1'b0, cfg.threshold_increment};
	assign thr_up   = thr_rise[16] ? LEVEL_MAX : thr_rise[15:0];
	assign thr_lim  = {1'b0, cfg.threshold_floor} + {1'b0, cfg.threshold_decrement};
	assign thr_dn   = ({1'b0, thr_q} < thr_lim) ? cfg.threshold_floor
	                                            : thr_q - cfg.threshold_decrement;
	assign rearm    = ({1'b0, level_q} + REARM_MARGIN) < {1'b0, thr_q};

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= in_data.accel_x;
			ay_q   <= in_data.accel_y;
			az_q   <= in_data.accel_z;
			now_q  <= in_data.now_ms;
			sum_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.square) begin
			sum_q <= sum_q + SUM_W'(axis_sq);
		end else if (cmd.root_step) begin
			sum_q <= sum_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.filt_a) begin
			acc_q <= 33'(32'(cfg.filter_gain) * 32'(mag_sat));
		end
		if (cmd.decide) begin
			pulse_q <= hit;
		end
		if (cmd.finish) begin
			out_q.smoothed_level    <= level_q;
			out_q.step_pulse        <= pulse_q;
			out_q.step_total        <= count_q;
			out_q.current_threshold <= thr_q;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			thr_q     <= RST_THR_START;
			latched_q <= 1'b0;
			last_ms_q <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.filt_b) begin
				level_q <= filt_sum[31:16];
			end
			if (thr_load) begin
				thr_q <= thr_load_val;
			end else if (cmd.decide) begin
				thr_q <= hit ? thr_up : thr_dn;
			end
			if (cmd.decide && hit) begin
				latched_q <= 1'b1;
				last_ms_q <= now_q;
				count_q   <= count_q + 32'd1;
			end else if (cmd.finish && rearm) begin
				latched_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_blocked = out_valid_q && !out_ready;
	assign out_valid          = out_valid_q;
	assign out_data           = out_q;

endmodule

FILE: design/adaptive_step_counter.sv
// top level of the adaptive step counter: configuration registers and wiring
//
// usage
// - input channel in_valid/in_ready/in_data carries one accelerometer item:
//   three signed axes and a millisecond timestamp
// - output channel out_valid/out_ready/out_data returns exactly one result per
//   item: smoothed level, step pulse, step total and the updated threshold
// - cfg_valid/cfg_ready/cfg_index/cfg_data writes the six settings; always
//   ready, write only while no item is in flight; writing threshold_start
//   also reloads the live threshold, unknown indexes are dropped
// - processing: after the accepting edge an item passes the squaring steps on
//   one shared multiplier, the bit-serial root at one bit per cycle, the
//   filter steps, decide and finish, then out_valid rises
// - throughput: one item in flight at a time, limited by the bit-serial
//   square root
// - the next item is taken as soon as the result sits in the output
//   register; a stalled receiver holds the finished result there and the
//   following item then waits in the finish cycle until the slot frees
// - reset clears the level, step count, timestamp and re-arms the detector;
//   the threshold and settings come back to their default values
module adaptive_step_counter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  asc_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output asc_pkg::out_item_t   out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  asc_pkg::cfg_index_t  cfg_index,
	input  logic [15:0]          cfg_data
);
	import asc_pkg::*;

	cfg_t         cfg_q;
	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	logic         cfg_wr;
	logic         thr_load;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// a write of the start value also restarts the live threshold
	assign thr_load  = cfg_wr && (cfg_index == REG_THR_START);

	// settings register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_gain         <= RST_FILTER_GAIN;
			cfg_q.threshold_start     <= RST_THR_START;
			cfg_q.threshold_increment <= RST_THR_INCREMENT;
			cfg_q.threshold_decrement <= RST_THR_DECREMENT;
			cfg_q.threshold_floor     <= RST_THR_FLOOR;
			cfg_q.step_gap_ms         <= RST_STEP_GAP;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FILTER_GAIN:   cfg_q.filter_gain         <= cfg_data;
				REG_THR_START:     cfg_q.threshold_start     <= cfg_data;
				REG_THR_INCREMENT: cfg_q.threshold_increment <= cfg_data;
				REG_THR_DECREMENT: cfg_q.threshold_decrement <= cfg_data;
				REG_THR_FLOOR:     cfg_q.threshold_floor     <= cfg_data;
				REG_STEP_GAP:      cfg_q.step_gap_ms         <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	asc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and detector state
	asc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_data      (in_data),
		.cfg          (cfg_q),
		.thr_load     (thr_load),
		.thr_load_val (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_data     (out_data)
	);

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted item");

	// a new result only comes out of the finish cycle, never while idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised without a finished item");

	// a stalled result stays put until the receiver takes it
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

endmodule

FILE: verif/tb_adaptive_step_counter.sv
`timescale 1ns / 100ps
// testbench of the adaptive step counter: directed and random samples checked against a predictor
module tb_adaptive_step_counter;
	import asc_pkg::*;

	// indexes past the last register, the block drops writes to them
	localparam cfg_index_t REG_SPARE_LO = 3'd6;
	localparam cfg_index_t REG_SPARE_HI = 3'd7;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 11;
	// comfortably past the time one item takes through the block
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASES        = 12;
	localparam int PHASE_SAMPLES = 105;
	localparam int MAX_GAP       = 40;

	// predictor of the step detector plus the queue of reports it expects
	class step_tracker;
		cfg_t        settings;
		logic [15:0] level;
		logic [15:0] threshold;
		logic        latched;
		logic [31:0] last_step;
		logic [31:0] steps;
		out_item_t   expected_reports[$];
		int          errors;

		function new();
			settings = '{RST_FILTER_GAIN, RST_THR_START, RST_THR_INCREMENT,
				RST_THR_DECREMENT, RST_THR_FLOOR, RST_STEP_GAP};
			level     = '0;
			threshold = RST_THR_START;
			latched   = 1'b0;
			last_step = '0;
			steps     = '0;
			errors    = 0;
		endfunction

		function void apply_setting(cfg_index_t idx, logic [15:0] value);
			case (idx)
				REG_FILTER_GAIN:   settings.filter_gain = value;
				REG_THR_START: begin
					// the live threshold is reloaded as well
					settings.threshold_start = value;
					threshold = value;
				end
				REG_THR_INCREMENT: settings.threshold_increment = value;
				REG_THR_DECREMENT: settings.threshold_decrement = value;
				REG_THR_FLOOR:     settings.threshold_floor = value;
				REG_STEP_GAP:      settings.step_gap_ms = value;
				default: ;
			endcase
		endfunction

		// largest root whose square stays within n, found bit by bit from the top
		function logic [16:0] floor_root(longint unsigned n);
			logic [16:0] root;
			logic [16:0] trial;
			root = '0;
			for (int b = 16; b >= 0; b--) begin
				trial = root | (17'd1 << b);
				if (longint'(trial) * longint'(trial) <= n)
					root = trial;
			end
			return root;
		endfunction

		function void note_sample(in_item_t s);
			longint          ax, ay, az;
			longint unsigned sum, g, blend;
			logic [16:0]     mag, rise;
			logic [31:0]     elapsed;
			out_item_t       r;
			ax  = s.accel_x;
			ay  = s.accel_y;
			az  = s.accel_z;
			sum = ax * ax + ay * ay + az * az;
			mag = floor_root(sum);
			if (mag > 17'd65535)
				mag = 17'd65535;
			g     = settings.filter_gain;
			blend = g * mag + (64'd65536 - g) * level + 64'd32768;
			level = blend[31:16];
			elapsed = s.now_ms - last_step;
			r.step_pulse = 1'b0;
			if (level > threshold && !latched && elapsed > settings.step_gap_ms) begin
				r.step_pulse = 1'b1;
				latched   = 1'b1;
				last_step = s.now_ms;
				steps     = steps + 1;
				rise = {1'b0, threshold} + settings.threshold_increment;
				threshold = (rise > 17'd65535) ? LEVEL_MAX : rise[15:0];
			end else if ({1'b0, threshold} <
					{1'b0, settings.threshold_floor} + settings.threshold_decrement) begin
				threshold = settings.threshold_floor;
			end else begin
				threshold = threshold - settings.threshold_decrement;
			end
			if ({1'b0, level} + REARM_MARGIN < {1'b0, threshold})
				latched = 1'b0;
			r.smoothed_level    = level;
			r.step_total        = steps;
			r.current_threshold = threshold;
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_report(out_item_t got);
			out_item_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: report with none expected, level %0d pulse %0d total %0d thr %0d",
					$time, got.smoothed_level, got.step_pulse, got.step_total,
					got.current_threshold);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("smoothed_level", want.smoothed_level, got.smoothed_level);
			compare_field("step_pulse", want.step_pulse, got.step_pulse);
			compare_field("step_total", want.step_total, got.step_total);
			compare_field("current_threshold", want.current_threshold, got.current_threshold);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	logic [15:0] cfg_data;

	step_tracker tracker;

	// idle percentages of the current phase
	int sender_idle_pct;
	int receiver_stall_pct;

	// walking pattern generator: triangle-shaped magnitude around gravity
	logic [31:0] walk_ms;
	int          gait_period;
	int          gait_pos;
	int          gait_amp;
	int          gait_dt;

	adaptive_step_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// receiver: ready changes on the falling edge, stalls at the phase's rate
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// every accepted report is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_report(out_data);
	end

	function automatic in_item_t sample_of(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [31:0] stamp);
		in_item_t s;
		s.accel_x = x;
		s.accel_y = y;
		s.accel_z = z;
		s.now_ms  = stamp;
		return s;
	endfunction

	// offer one item, entered and left on a falling edge
	task automatic push_sample(in_item_t s);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		tracker.note_sample(s);
		@(negedge clk);
	endtask

	// valid is left high, the caller lowers it after the last write
	task automatic cfg_write(cfg_index_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.apply_setting(idx, value);
		@(negedge clk);
	endtask

	// wait for every report, then let the pipeline settle
	task automatic wait_quiet();
		while (tracker.expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic start_gait();
		gait_period = $urandom_range(8, 40);
		gait_amp    = $urandom_range(100, 2000);
		gait_dt     = $urandom_range(4, 60);
		gait_pos    = $urandom_range(0, 39);
	endtask

	// one phase's settings: extremes first, then random plausible values
	task automatic load_settings(int phase);
		cfg_t c;
		case (phase)
			1: c = '{16'd65535, 16'd1408, 16'd64, 16'd6, 16'd1344, 16'd300};
			2: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
			3: c = '{16'd32768, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0};
			4: c = '{16'd1, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
			5: c = '{16'd40000, 16'd100, 16'd50, 16'd65535, 16'd0, 16'd0};
			default: begin
				c.filter_gain         = 16'($urandom_range(3000, 65535));
				c.threshold_start     = 16'($urandom_range(600, 2600));
				c.threshold_increment = 16'($urandom_range(0, 300));
				c.threshold_decrement = 16'($urandom_range(0, 40));
				c.threshold_floor     = 16'($urandom_range(300, 2000));
				c.step_gap_ms         = 16'($urandom_range(0, 600));
			end
		endcase
		cfg_write(REG_SPARE_LO, 16'($urandom));
		cfg_write(REG_FILTER_GAIN, c.filter_gain);
		cfg_write(REG_THR_START, c.threshold_start);
		cfg_write(REG_THR_INCREMENT, c.threshold_increment);
		cfg_write(REG_THR_DECREMENT, c.threshold_decrement);
		cfg_write(REG_THR_FLOOR, c.threshold_floor);
		cfg_write(REG_STEP_GAP, c.step_gap_ms);
		cfg_write(REG_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// step scenarios at default settings, then the extremes of the axes
	task automatic run_directed();
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd0));
		// level crosses the threshold on the second strong sample
		push_sample(sample_of(16'd0, 16'd0, 16'd4000, 32'd400));
		push_sample(sample_of(16'd0, 16'd0, 16'd4000, 32'd410));
		// level drops far enough to re-arm
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd420));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd430));
		// exactly the step gap since the last step: no step, one more ms: step
		push_sample(sample_of(16'd0, 16'd0, 16'd4000, 32'd710));
		push_sample(sample_of(16'd0, 16'd0, 16'd4000, 32'd711));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd720));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd730));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'd740));
		// timestamp close to the wrap, then past it
		push_sample(sample_of(16'd0, 16'd0, -16'sd4000, 32'hFFFF_FF00));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'hFFFF_FF10));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'hFFFF_FF20));
		push_sample(sample_of(16'd0, 16'd0, 16'd0, 32'hFFFF_FF30));
		push_sample(sample_of(-16'sd4000, 16'd0, 16'd0, 32'h0000_0050));
		push_sample(sample_of(-16'sd4000, 16'd0, 16'd0, 32'h0000_0051));
		// largest magnitudes and sign mixes
		push_sample(sample_of(16'sd32767, 16'sd32767, 16'sd32767, 32'h0000_1000));
		push_sample(sample_of(-16'sd32768, -16'sd32768, -16'sd32768, 32'h0000_1001));
		push_sample(sample_of(-16'sd32768, 16'sd32767, -16'sd1, 32'hFFFF_FFFF));
		push_sample(sample_of(16'sd1, -16'sd1, 16'd0, 32'h8000_0000));
	endtask

	// mostly walking sequences, the rest noise, time jumps and broken gaits
	task automatic run_samples(int count);
		in_item_t s;
		int       kind;
		int       pos;
		int       span;
		int       mag;
		logic [15:0] held;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			if (kind >= 80 && kind < 90) begin
				s.accel_x = 16'($urandom);
				s.accel_y = 16'($urandom);
				s.accel_z = 16'($urandom);
				s.now_ms  = $urandom;
			end else begin
				if (kind >= 95)
					start_gait();
				else if (kind >= 90)
					walk_ms += $urandom;
				pos  = gait_pos % gait_period;
				gait_pos++;
				span = (pos < gait_period / 2) ? pos : gait_period - pos;
				mag  = 1256 - gait_amp / 2 + (gait_amp * span * 2) / gait_period;
				walk_ms += gait_dt + $urandom_range(0, 3);
				s.accel_x = 16'($urandom_range(0, 300) - 150);
				s.accel_y = 16'($urandom_range(0, 300) - 150);
				s.accel_z = 16'($urandom_range(0, 1) ? mag : -mag);
				// gravity on another axis now and then
				if ($urandom_range(0, 3) == 0) begin
					held      = s.accel_x;
					s.accel_x = s.accel_z;
					s.accel_z = held;
				end
				s.now_ms = walk_ms;
			end
			push_sample(s);
		end
	endtask

	initial begin
		tracker            = new();
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		in_data            = '0;
		cfg_valid          = 1'b0;
		cfg_index          = REG_FILTER_GAIN;
		cfg_data           = '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		walk_ms            = '0;
		start_gait();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// settings change only with nothing in flight
			if (p > 0) begin
				wait_quiet();
				load_settings(p);
			end
			case (p % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
				default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
			endcase
			walk_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
				: $urandom;
			start_gait();
			if (p == 0)
				run_directed();
			run_samples(PHASE_SAMPLES);
			// the last item is taken, take valid down
			in_valid <= 1'b0;
		end

		wait_quiet();
		if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
design/asc_pkg.sv
design/asc_ctrl.sv
design/asc_datapath.sv
design/adaptive_step_counter.sv
verif/tb_adaptive_step_counter.sv
